>>> design/m3f_pkg.sv
// Shared types, sizes and helper functions of the 3x3 median filter.
// Used by the top level median3x3_filter; no dependencies of its own.

package m3f_pkg;

   // frame limits and field widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIX_W      = 8;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int LINE_W     = 2 * PIX_W;

   localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
   localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

   typedef logic [PIX_W-1:0] pix_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // one window column, kept sorted
   typedef struct packed {
      pix_type lo;
      pix_type mid;
      pix_type hi;
   } col_type;

   // which results an item produces:
   //   sel[0] median of the pixel up-left, sel[1] right border of the row above,
   //   sel[2] bottom row pixel to the left, sel[3] bottom-right corner
   typedef struct packed {
      logic       is_med;
      logic [3:0] sel;
   } emit_type;

   function automatic pix_type min2(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type min3(input pix_type a, input pix_type b, input pix_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pix_type max3(input pix_type a, input pix_type b, input pix_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic col_type sort3(input pix_type a, input pix_type b, input pix_type c);
      col_type s;
      s.lo  = min3(a, b, c);
      s.mid = med3(a, b, c);
      s.hi  = max3(a, b, c);
      return s;
   endfunction

endpackage

>>> design/median3x3_filter.sv
// 3x3 median filter: an item passes stages A, B and C before its first result is offered.
// Throughput: one pixel per cycle while each pixel yields at most one result and the output
// takes every result; a pixel that yields several results (row ends, last row) stays in the
// result stage until its last result is taken and stalls the input while the others are pending.
// The line store (one 1024 x 16 RAM, both previous rows) is read and written once per pixel.
// Reset: width 640, height 480, row/column counters 0, window 0; the line store is not
// cleared and its unwritten entries only ever reach border positions.

module median3x3_filter
   import m3f_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_pixel_in,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic [ROW_W-1:0]      rsp_out_row,
   output logic [COL_W-1:0]      rsp_out_col,
   output logic                  rsp_run_last,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration and frame position
   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [COL_W-1:0]  w_last;
   logic [ROW_W-1:0]  h_last;
   logic              csr_xfer;
   logic              csr_hit;

   // pipeline control
   logic              pipe_en;
   logic              req_xfer;
   logic              rsp_xfer;
   emit_type          emit_new;

   // stage A: line store read in flight
   logic              a_vld_ff, a_vld_in;
   pix_type           a_px_ff;
   logic [ROW_W-1:0]  a_row_ff;
   logic [COL_W-1:0]  a_col_ff;
   emit_type          a_emit_ff;
   logic              fwd_ff, fwd_in;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] ram_rd_data;
   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wr;
   logic              line_we;
   col_type           col_new;

   // stage B: window
   col_type           win_ff [3];
   col_type           win_in [3];
   logic              b_vld_ff;
   logic [ROW_W-1:0]  b_row_ff;
   logic [COL_W-1:0]  b_col_ff;
   emit_type          b_emit_ff;

   // stage C: column reductions
   logic              c_vld_ff;
   pix_type           c_lo_ff, c_mid_ff, c_hi_ff;
   logic [ROW_W-1:0]  c_row_ff;
   logic [COL_W-1:0]  c_col_ff;
   emit_type          c_emit_ff;

   // result stage: one item, up to four results
   logic [3:0]        x_sel_ff, x_sel_in;
   logic [3:0]        x_sel_rest;
   pix_type           x_med_ff;
   logic [ROW_W-1:0]  x_row_ff;
   logic [COL_W-1:0]  x_col_ff;

   // effective frame size, saturated to the legal range
   always_comb begin
      if (fw_ff == '0) begin
         w_last = '0;
      end else if (fw_ff > FW_W'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(fw_ff - 1'b1);
      end
      if (fh_ff == '0) begin
         h_last = '0;
      end else if (fh_ff > FH_W'(MAX_HEIGHT)) begin
         h_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         h_last = ROW_W'(fh_ff - 1'b1);
      end
   end

   // handshakes
   assign x_sel_rest = x_sel_ff & (x_sel_ff - 4'd1);
   assign rsp_valid  = (x_sel_ff != '0);
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pipe_en    = (x_sel_rest == '0) && ((x_sel_ff == '0) || rsp_ready);
   assign req_ready  = pipe_en;
   assign req_xfer   = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid && csr_ready;

   // configuration registers and frame counters
   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      csr_hit = 1'b0;
      if (csr_xfer) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               fw_in   = csr_wdata[FW_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               fh_in   = csr_wdata;
               csr_hit = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
      row_in = row_ff;
      col_in = col_ff;
      if (csr_hit) begin
         row_in = '0;
         col_in = '0;
      end else if (req_xfer) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // which results the incoming pixel produces
   always_comb begin
      emit_new.is_med = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
      emit_new.sel[0] = (row_ff != '0) && (col_ff != '0);
      emit_new.sel[1] = (row_ff != '0) && (col_ff == w_last);
      emit_new.sel[2] = (row_ff == h_last) && (col_ff != '0);
      emit_new.sel[3] = (row_ff == h_last) && (col_ff == w_last);
   end

   // line store: entry holds {row r-2, row r-1} of its column
   m3f_ram #(
      .WIDTH(LINE_W),
      .DEPTH(MAX_WIDTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (line_we),
      .wr_addr(a_col_ff),
      .wr_data(line_wr),
      .rd_en  (pipe_en),
      .rd_addr(col_ff),
      .rd_data(ram_rd_data)
   );

   // read-modify-write; a one-pixel-wide frame hits the same entry back to back
   assign line_rd = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign line_wr = {line_rd[PIX_W-1:0], a_px_ff};
   assign line_we = pipe_en && a_vld_ff;
   assign fwd_in  = req_xfer && a_vld_ff && (col_ff == a_col_ff);
   assign a_vld_in = req_xfer;

   // new window column sorted on entry
   assign col_new = sort3(line_rd[LINE_W-1:PIX_W], line_rd[PIX_W-1:0], a_px_ff);

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = col_new;
   end

   // result stage next state
   always_comb begin
      x_sel_in = x_sel_ff;
      if (pipe_en) begin
         x_sel_in = c_vld_ff ? c_emit_ff.sel : '0;
      end else if (rsp_xfer) begin
         x_sel_in = x_sel_rest;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= RESET_WIDTH;
         fh_ff    <= RESET_HEIGHT;
         row_ff   <= '0;
         col_ff   <= '0;
         a_vld_ff <= 1'b0;
         fwd_ff   <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         x_sel_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         fw_ff    <= fw_in;
         fh_ff    <= fh_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         x_sel_ff <= x_sel_in;
         if (pipe_en) begin
            a_vld_ff <= a_vld_in;
            fwd_ff   <= fwd_in;
            b_vld_ff <= a_vld_ff;
            c_vld_ff <= b_vld_ff;
            if (a_vld_ff) begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[i] <= win_in[i];
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_px_ff     <= req_pixel_in;
         a_row_ff    <= row_ff;
         a_col_ff    <= col_ff;
         a_emit_ff   <= emit_new;
         fwd_data_ff <= line_wr;
         b_row_ff    <= a_row_ff;
         b_col_ff    <= a_col_ff;
         b_emit_ff   <= a_emit_ff;
         c_lo_ff     <= max3(win_ff[0].lo, win_ff[1].lo, win_ff[2].lo);
         c_mid_ff    <= med3(win_ff[0].mid, win_ff[1].mid, win_ff[2].mid);
         c_hi_ff     <= min3(win_ff[0].hi, win_ff[1].hi, win_ff[2].hi);
         c_row_ff    <= b_row_ff;
         c_col_ff    <= b_col_ff;
         c_emit_ff   <= b_emit_ff;
         x_med_ff    <= c_emit_ff.is_med ? med3(c_lo_ff, c_mid_ff, c_hi_ff) : '0;
         x_row_ff    <= c_row_ff;
         x_col_ff    <= c_col_ff;
      end
   end

   // result selection, lowest pending result first
   always_comb begin
      rsp_run_last = (x_sel_rest == '0);
      if (x_sel_ff[0]) begin
         rsp_pixel_out = x_med_ff;
         rsp_out_row   = x_row_ff - 1'b1;
         rsp_out_col   = x_col_ff - 1'b1;
      end else if (x_sel_ff[1]) begin
         rsp_pixel_out = '0;
         rsp_out_row   = x_row_ff - 1'b1;
         rsp_out_col   = x_col_ff;
      end else if (x_sel_ff[2]) begin
         rsp_pixel_out = '0;
         rsp_out_row   = x_row_ff;
         rsp_out_col   = x_col_ff - 1'b1;
      end else begin
         rsp_pixel_out = '0;
         rsp_out_row   = x_row_ff;
         rsp_out_col   = x_col_ff;
      end
   end

   // checks
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= w_last) && (row_ff <= h_last))
      else $error("frame position beyond configured size");

   a_more_results: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_run_last |=> rsp_valid)
      else $error("pending results lost after a transfer");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_ready && rsp_run_last) |-> !req_ready)
      else $error("input taken while results still pending");

   a_stage_a_hold: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !pipe_en |=> a_vld_ff && $stable(a_col_ff) && $stable(a_px_ff))
      else $error("stage A item changed while stalled");

endmodule

>>> design/m3f_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.

module m3f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
